// File: hdl/stream_duplicate_filter_assert.svh
// Assertion macros for the duplicate filter RTL.
// No dependencies; included by stream_duplicate_filter, which carries concurrent checks.
`ifndef STREAM_DUPLICATE_FILTER_ASSERT_SVH
`define STREAM_DUPLICATE_FILTER_ASSERT_SVH

// Check outside reset: disabled while rst_n is low.
`define SDF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define SDF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sdf_pkg.sv
// Package for the duplicate filter: data width, default table depth,
// probe word passed along the cell chain, and controller states.
package sdf_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned DEPTH_DEF = 64;

	// word that walks the chain, one cell per cycle
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] val;
		logic              hit;
	} probe_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_PEND
	} state_t;

endpackage

// File: hdl/sdf_cell.sv
// One cell of the seen-value chain: holds one table entry, compares it with the
// passing probe and writes the probe value when it is the next free slot.
// Depends on sdf_pkg.
module sdf_cell #(
	parameter int unsigned DEPTH = sdf_pkg::DEPTH_DEF,
	parameter int unsigned IDX   = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  sdf_pkg::probe_t        probe_in,
	output sdf_pkg::probe_t        probe_out
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [sdf_pkg::DATA_W-1:0] entry_q;
	logic                       active;
	logic                       match;
	logic                       wr_en;

	always_comb begin
		active = (count > CW'(IDX));
		match  = active && (entry_q == probe_in.val);
		// all earlier cells have been checked once the probe reaches the free slot
		wr_en  = probe_in.vld && !probe_in.hit && (count == CW'(IDX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out.vld <= probe_in.vld;
			probe_out.val <= probe_in.val;
			probe_out.hit <= probe_in.hit | match;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= probe_in.val;
		end
	end

endmodule

// File: hdl/stream_duplicate_filter.sv
// Channel | signals                                  | role
// --------+------------------------------------------+---------------------------
// in      | in_valid, in_ready, value, end_of_list   | list elements, last flagged
// out     | out_valid, out_ready, value_out, keep,   | one result word per input
//         | end_out, overflow                        | word, same order
//
// An accepted word walks the chain of DEPTH cells, one cell per cycle. When it leaves
// the chain its result is held in the controller, then moves to the output register
// once that is free. The next word can enter only after that move.
// in_ready is high only while the chain is empty; the output register lets the
// next word enter while a result still waits for out_ready.
// A finished result waits in the controller while the output register is full.
// Reset empties the table (seen count zero); no clearing pass is needed.
module stream_duplicate_filter #(
	parameter int unsigned DEPTH = sdf_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] value,
	input  logic        end_of_list,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] value_out,
	output logic        keep,
	output logic        end_out,
	output logic        overflow
);

	`include "stream_duplicate_filter_assert.svh"

	localparam int unsigned CW = $clog2(DEPTH + 1);

	sdf_pkg::probe_t chain [DEPTH+1];
	logic [DEPTH-1:0] vld_vec;

	sdf_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          last_q;
	logic [31:0]   res_val_q;
	logic          res_keep_q;
	logic          res_ovf_q;
	logic          res_last_q;
	logic          out_valid_q;
	logic [31:0]   out_val_q;
	logic          out_keep_q;
	logic          out_end_q;
	logic          out_ovf_q;

	logic accept;
	logic done;
	logic full;
	logic load_out;

	assign accept = in_valid && in_ready;
	assign done   = chain[DEPTH].vld;
	assign full   = (count_q == CW'(DEPTH));

	always_comb begin
		chain[0].vld = accept;
		chain[0].val = value;
		chain[0].hit = 1'b0;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sdf_cell #(
			.DEPTH(DEPTH),
			.IDX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.probe_in (chain[k]),
			.probe_out(chain[k+1])
		);
		assign vld_vec[k] = chain[k+1].vld;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sdf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = sdf_pkg::ST_WALK;
				end
			end
			sdf_pkg::ST_WALK: begin
				if (done) begin
					state_d = sdf_pkg::ST_PEND;
				end
			end
			sdf_pkg::ST_PEND: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = sdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdf_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				if (last_q) begin
					count_q <= '0;
				end else if (!chain[DEPTH].hit && !full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= end_of_list;
		end
		if (done) begin
			res_val_q  <= chain[DEPTH].val;
			res_keep_q <= !chain[DEPTH].hit;
			res_ovf_q  <= !chain[DEPTH].hit && full;
			res_last_q <= last_q;
		end
		if (load_out) begin
			out_val_q  <= res_val_q;
			out_keep_q <= res_keep_q;
			out_end_q  <= res_last_q;
			out_ovf_q  <= res_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = signed'(out_val_q);
	assign keep      = out_keep_q;
	assign end_out   = out_end_q;
	assign overflow  = out_ovf_q;

	`SDF_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "seen count above depth")
	`SDF_ASSERT_ALWAYS(a_one_probe, clk, $onehot0(vld_vec), "more than one word in the chain")
	`SDF_ASSERT(a_idle_empty, clk, arst_n, in_ready |-> !(|vld_vec), "input open with word in chain")
	`SDF_ASSERT(a_ovf_keep, clk, arst_n, (out_valid && overflow) |-> keep, "overflow on dropped word")
	`SDF_ASSERT(a_done_walk, clk, arst_n, done |-> (state_q == sdf_pkg::ST_WALK), "chain exit outside walk")

endmodule

// File: sim/dup_filter_checker.sv
// Checker for stream_duplicate_filter: watches both channels, keeps its own
// seen table per list and compares every result word with the oldest prediction.
// Depends on sdf_pkg for the default table depth.
`timescale 1ns / 100ps

module dup_filter_checker #(
	parameter int unsigned DEPTH = sdf_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               end_of_list,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] value_out,
	input  logic               keep,
	input  logic               end_out,
	input  logic               overflow,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] val;
		logic               keep;
		logic               last;
		logic               ovf;
	} filt_word_t;

	logic signed [31:0] seen_tbl [DEPTH];
	int                 seen_num = 0;
	filt_word_t         expected_words [$];
	int                 err_cnt = 0;
	int                 out_idx = 0;
	int                 pend_q = 0;

	assign errors  = err_cnt;
	assign pending = pend_q;

	task automatic report_fail(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		err_cnt++;
	endtask

	// first occurrence is kept and stored; a full table keeps new values unstored
	task automatic predict_filter(input logic signed [31:0] v, input logic last,
		output filt_word_t r);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < seen_num; i++)
			if (seen_tbl[i] == v)
				hit = 1'b1;
		r.val  = v;
		r.keep = !hit;
		r.last = last;
		r.ovf  = 1'b0;
		if (!hit) begin
			if (seen_num < DEPTH) begin
				seen_tbl[seen_num] = v;
				seen_num++;
			end else begin
				r.ovf = 1'b1;
			end
		end
		if (last)
			seen_num = 0;
	endtask

	always @(posedge clk) begin : watch
		filt_word_t want, pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_fail($sformatf("word %0d: result %0d with nothing expected",
						out_idx, value_out));
				end else begin
					want = expected_words.pop_front();
					if (value_out !== want.val)
						report_fail($sformatf("word %0d: value_out %0d, want %0d",
							out_idx, value_out, want.val));
					if (keep !== want.keep)
						report_fail($sformatf("word %0d: keep %b, want %b",
							out_idx, keep, want.keep));
					if (end_out !== want.last)
						report_fail($sformatf("word %0d: end_out %b, want %b",
							out_idx, end_out, want.last));
					if (overflow !== want.ovf)
						report_fail($sformatf("word %0d: overflow %b, want %b",
							out_idx, overflow, want.ovf));
				end
				out_idx++;
			end
			if (in_valid && in_ready) begin
				predict_filter(value, end_of_list, pred);
				expected_words.push_back(pred);
			end
			pend_q <= expected_words.size();
		end
	end

endmodule

// File: sim/tb.sv
// Testbench top for stream_duplicate_filter: clock, reset, list stimulus and
// receiver back-pressure; dup_filter_checker does prediction and compare.
// Depends on sdf_pkg, stream_duplicate_filter and dup_filter_checker.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned DEPTH       = sdf_pkg::DEPTH_DEF;
	localparam int          PHASE_ITEMS = 250;
	localparam int          HOLD_AT     = 330;
	localparam int          HOLD_CYCLES = 600;
	localparam int          CYCLE_LIMIT = 500000;

	localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic signed [31:0] VAL_NEG = 32'hFFFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] value;
	logic               end_of_list;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value_out;
	logic               keep;
	logic               end_out;
	logic               overflow;

	int err_cnt;
	int pending;
	int sent_cnt = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 73;
	int cycle_cnt = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stream_duplicate_filter #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .end_of_list(end_of_list),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_out(value_out), .keep(keep), .end_out(end_out), .overflow(overflow)
	);

	dup_filter_checker #(.DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.value(value), .end_of_list(end_of_list),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_out(value_out), .keep(keep), .end_out(end_out), .overflow(overflow),
		.errors(err_cnt), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random ready, plus one long hold-off so the block backs up
	initial begin : receiver
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_used && sent_cnt >= HOLD_AT) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic signed [31:0] v, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		value       <= v;
		end_of_list <= last;
		do @(posedge clk); while (!in_ready);
		sent_cnt++;
	endtask

	task automatic wait_drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// short lists mostly draw from a small pool to force repeats; long lists run the
	// table past full, mixing in repeats of stored and of unstored values
	task automatic send_random_list(input bit long_list);
		logic signed [31:0] pool [8];
		logic signed [31:0] base;
		int len, nxt, extra;
		bit wide;
		wide = ($urandom_range(0, 4) == 0);
		base = $urandom;
		for (int k = 0; k < 8; k++) begin
			case ($urandom_range(0, 5))
				0: pool[k] = VAL_MIN;
				1: pool[k] = VAL_MAX;
				2: pool[k] = $urandom_range(0, 3);
				default: pool[k] = $urandom;
			endcase
		end
		if (long_list) begin
			nxt   = 0;
			extra = $urandom_range(2, 6);
			while (nxt < DEPTH + extra) begin
				if (nxt > 0 && $urandom_range(0, 15) < (nxt >= DEPTH ? 8 : 1)) begin
					send_word(base + $urandom_range(0, nxt - 1), 1'b0);
				end else begin
					nxt++;
					send_word(base + nxt - 1, nxt == DEPTH + extra);
				end
			end
		end else begin
			len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				send_word(wide ? $signed($urandom) : pool[$urandom_range(0, 7)],
					k == len - 1);
		end
	endtask

	initial begin : stimulus
		int n_lists;
		int phase_end;
		in_valid    = 1'b0;
		value       = '0;
		end_of_list = 1'b0;
		arst_n      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, then their repeats in the same list
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(VAL_NEG, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_NEG, 1'b0);
		send_word(32'sd0, 1'b1);
		// table must be clear again after the last word
		send_word(VAL_MIN, 1'b1);
		send_word(32'sh5555_5555, 1'b0);
		send_word(32'hAAAA_AAAA, 1'b0);
		send_word(32'sh5555_5555, 1'b1);
		send_word(32'sd7, 1'b0);
		send_word(32'sd7, 1'b0);
		send_word(32'sd7, 1'b1);
		send_word(VAL_NEG, 1'b1);

		n_lists = 0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 22; recv_idle_pct = 73; end
				1: begin send_idle_pct = 73; recv_idle_pct = 22; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_end = sent_cnt + PHASE_ITEMS;
			while (sent_cnt < phase_end) begin
				send_random_list(n_lists % 30 == 5);
				n_lists++;
			end
			// sender pauses here until every result is back
			in_valid <= 1'b0;
			wait_drain();
		end

		repeat (DEPTH + 8) @(posedge clk);
		if (err_cnt == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
